[hw/rtl/page_frame_allocator_macros.svh]
// Assertion macros shared by the page frame allocator modules.
`ifndef PAGE_FRAME_ALLOCATOR_MACROS_SVH
`define PAGE_FRAME_ALLOCATOR_MACROS_SVH

// Same-cycle implication, disabled while reset is asserted.
`define PFA_ASSERT_NOW(label, clk, rst_n, ante, cons) \
	label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
		else $error("page frame allocator: same-cycle check failed");

// Next-cycle implication, disabled while reset is asserted.
`define PFA_ASSERT_NEXT(label, clk, rst_n, ante, cons) \
	label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
		else $error("page frame allocator: next-cycle check failed");

`endif

[hw/rtl/pfa_pkg.sv]
// Types and constants shared by the page frame allocator modules.
package pfa_pkg;

	// Default frame count and fixed table depth.
	localparam int DEF_NUM_FRAMES = 8;
	localparam int TABLE_DEPTH    = 8;
	localparam int TABLE_IDX_W    = $clog2(TABLE_DEPTH);

	// Depth of the command queue between front and back.
	localparam int CMD_DEPTH = 2;

	// Request opcodes.
	typedef enum logic [1:0] {
		OP_ALLOC   = 2'd0,
		OP_RELEASE = 2'd1,
		OP_QUERY   = 2'd2
	} op_t;

	// Result status codes.
	typedef enum logic [1:0] {
		ST_OK        = 2'd0,
		ST_NO_FRAMES = 2'd1,
		ST_HELD      = 2'd2,
		ST_NONE      = 2'd3
	} status_t;

	// Work kinds handed from the front to the back.
	typedef enum logic [1:0] {
		CMD_SINGLE  = 2'd0,
		CMD_ALLOC   = 2'd1,
		CMD_RELEASE = 2'd2,
		CMD_QUERY   = 2'd3
	} cmd_kind_t;

	// One queued command: what to do, for how many pages, and the reported free count.
	typedef struct packed {
		cmd_kind_t  kind;
		status_t    status;
		logic [3:0] count;
		logic [3:0] free_frames;
	} cmd_t;

	// One result item.
	typedef struct packed {
		logic       last;
		logic [3:0] free_frames;
		logic       entry_valid;
		logic [2:0] frame_index;
		logic [2:0] page_index;
		status_t    status;
	} result_t;

endpackage

[hw/rtl/page_frame_allocator.sv]
// Usage: bitmap page frame allocator with one page table and stream ports.
// Requests enter on the s_ channel (op and page count); results leave on the
// m_ channel, one transaction per result, with tlast on the final result of
// each request. Allocate emits one result per page mapped; query emits the
// stored mappings in page order; release, errors and empty tables emit one.
// The front takes one request per cycle while its two-entry command queue
// has room. The back takes a command from the queue, then steps through
// its pages: while the receiver takes results, allocate and query emit one
// result per cycle, and release frees one frame per cycle before its single
// result. A request maps at most eight pages, and the back takes no new
// command until it is through with the last; this sequencer, stepping one
// table entry per cycle unless the output stalls, sets the rate. Requests
// pass through the command queue and the sequencer to the output register,
// and a release reports only after it has freed all of its frames.
// Reset frees all frames and drops the table; no clearing pass is needed.
// When the receiver stalls, the held result stays on m_tdata, the back
// waits, and requests keep entering until the queue is full.
module page_frame_allocator
	import pfa_pkg::*;
#(
	parameter int NUM_FRAMES = DEF_NUM_FRAMES
) (
	input  logic        clk,
	input  logic        arst_n,
	input  logic        s_tvalid,
	output logic        s_tready,
	input  logic [7:0]  s_tdata,  // op[1:0], page_request[5:2], zeros above
	output logic        m_tvalid,
	input  logic        m_tready,
	output logic [15:0] m_tdata,  // status[1:0], page_index[4:2], frame_index[7:5],
	                              // entry_valid[8], free_frames[12:9], zeros above
	output logic        m_tlast
);

	logic    push;
	cmd_t    push_cmd;
	logic    queue_full;
	logic    pop;
	cmd_t    head_cmd;
	logic    queue_empty;
	result_t result;

	// Request classification and bookkeeping.
	pfa_front #(
		.NUM_FRAMES(NUM_FRAMES)
	) u_front (
		.clk         (clk),
		.arst_n      (arst_n),
		.in_valid    (s_tvalid),
		.in_ready    (s_tready),
		.op          (s_tdata[1:0]),
		.page_request(s_tdata[5:2]),
		.push        (push),
		.push_cmd    (push_cmd),
		.queue_full  (queue_full)
	);

	// Command queue between the two halves.
	pfa_cmd_fifo u_fifo (
		.clk     (clk),
		.arst_n  (arst_n),
		.push    (push),
		.push_cmd(push_cmd),
		.full    (queue_full),
		.pop     (pop),
		.head_cmd(head_cmd),
		.empty   (queue_empty)
	);

	// Frame search, table access and result output.
	pfa_back #(
		.NUM_FRAMES(NUM_FRAMES)
	) u_back (
		.clk        (clk),
		.arst_n     (arst_n),
		.head_cmd   (head_cmd),
		.queue_empty(queue_empty),
		.pop        (pop),
		.out_valid  (m_tvalid),
		.out_ready  (m_tready),
		.out_result (result)
	);

	// Pack the result fields onto the output stream.
	assign m_tdata = {3'b000, result.free_frames, result.entry_valid,
		result.frame_index, result.page_index, result.status};
	assign m_tlast = result.last;

endmodule

[hw/rtl/pfa_cmd_fifo.sv]
// Short command queue between the front and the back of the allocator.
`include "page_frame_allocator_macros.svh"

module pfa_cmd_fifo
	import pfa_pkg::*;
(
	input  logic clk,
	input  logic arst_n,
	input  logic push,
	input  cmd_t push_cmd,
	output logic full,
	input  logic pop,
	output cmd_t head_cmd,
	output logic empty
);

	localparam int PTR_W = (CMD_DEPTH > 1) ? $clog2(CMD_DEPTH) : 1;
	localparam int CNT_W = $clog2(CMD_DEPTH + 1);

	cmd_t             mem_q [CMD_DEPTH];
	logic [PTR_W-1:0] wr_q;
	logic [PTR_W-1:0] rd_q;
	logic [CNT_W-1:0] count_q;

	assign full     = (count_q == CNT_W'(CMD_DEPTH));
	assign empty    = (count_q == '0);
	assign head_cmd = mem_q[rd_q];

	// Storage is written at the write pointer.
	always_ff @(posedge clk) begin
		if (push) begin
			mem_q[wr_q] <= push_cmd;
		end
	end

	// Pointers and occupancy.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wr_q    <= '0;
			rd_q    <= '0;
			count_q <= '0;
		end else begin
			if (push) begin
				wr_q <= (wr_q == PTR_W'(CMD_DEPTH - 1)) ? '0 : wr_q + 1'b1;
			end
			if (pop) begin
				rd_q <= (rd_q == PTR_W'(CMD_DEPTH - 1)) ? '0 : rd_q + 1'b1;
			end
			if (push && !pop) begin
				count_q <= count_q + 1'b1;
			end else if (pop && !push) begin
				count_q <= count_q - 1'b1;
			end
		end
	end

	// Occupancy never passes the depth, and a pop never hits an empty queue.
	`PFA_ASSERT_NOW(a_fifo_bound, clk, arst_n, 1'b1, count_q <= CNT_W'(CMD_DEPTH))
	`PFA_ASSERT_NOW(a_fifo_pop_nonempty, clk, arst_n, pop, count_q != '0)
	`PFA_ASSERT_NOW(a_fifo_push_not_full, clk, arst_n, push, !full)

endmodule

[hw/rtl/pfa_front.sv]
// Front of the allocator: accepts requests, keeps the bookkeeping and queues work.
`include "page_frame_allocator_macros.svh"

module pfa_front
	import pfa_pkg::*;
#(
	parameter int NUM_FRAMES = DEF_NUM_FRAMES
) (
	input  logic       clk,
	input  logic       arst_n,
	input  logic       in_valid,
	output logic       in_ready,
	input  logic [1:0] op,
	input  logic [3:0] page_request,
	output logic       push,
	output cmd_t       push_cmd,
	input  logic       queue_full
);

	localparam int FREE_W = $clog2(NUM_FRAMES + 1);
	localparam int CMP_W  = (FREE_W > 4) ? FREE_W : 4;

	logic              table_active_q;
	logic [3:0]        page_count_q;
	logic [FREE_W-1:0] free_q;

	logic              accept;
	logic              emit;
	logic              too_big;
	logic [FREE_W-1:0] free_d;
	logic [3:0]        page_count_d;
	logic              table_active_d;

	assign in_ready = !queue_full;
	assign accept   = in_valid && in_ready;
	assign push     = accept && emit;

	// A request is too large if it exceeds the free frames or the table depth.
	assign too_big = (CMP_W'(page_request) > CMP_W'(free_q)) ||
		(page_request > 4'(TABLE_DEPTH));

	// Classify the request and work out the bookkeeping after it.
	always_comb begin
		emit           = 1'b1;
		free_d         = free_q;
		page_count_d   = page_count_q;
		table_active_d = table_active_q;
		push_cmd       = '{kind: CMD_SINGLE, status: ST_OK, count: 4'd0,
			free_frames: 4'(free_q)};
		case (op)
			OP_ALLOC: begin
				if (table_active_q) begin
					push_cmd.status = ST_HELD;
				end else if (too_big) begin
					push_cmd.status = ST_NO_FRAMES;
				end else begin
					free_d               = free_q - FREE_W'(page_request);
					page_count_d         = page_request;
					table_active_d       = 1'b1;
					push_cmd.free_frames = 4'(free_d);
					push_cmd.count       = page_request;
					if (page_request != 4'd0) begin
						push_cmd.kind = CMD_ALLOC;
					end
				end
			end
			OP_RELEASE: begin
				if (!table_active_q) begin
					push_cmd.status = ST_NONE;
				end else begin
					free_d               = free_q + FREE_W'(page_count_q);
					table_active_d       = 1'b0;
					push_cmd.free_frames = 4'(free_d);
					push_cmd.count       = page_count_q;
					if (page_count_q != 4'd0) begin
						push_cmd.kind = CMD_RELEASE;
					end
				end
			end
			OP_QUERY: begin
				if (!table_active_q) begin
					push_cmd.status = ST_NONE;
				end else begin
					push_cmd.count = page_count_q;
					if (page_count_q != 4'd0) begin
						push_cmd.kind = CMD_QUERY;
					end
				end
			end
			default: begin
				emit = 1'b0;
			end
		endcase
	end

	// Bookkeeping registers, updated on each accepted transaction.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			table_active_q <= 1'b0;
			page_count_q   <= 4'd0;
			free_q         <= FREE_W'(NUM_FRAMES);
		end else if (accept) begin
			table_active_q <= table_active_d;
			page_count_q   <= page_count_d;
			free_q         <= free_d;
		end
	end

	// The free count stays within the frame count, and a held table's page count stays within the table depth.
	`PFA_ASSERT_NOW(a_front_free_bound, clk, arst_n, 1'b1, free_q <= FREE_W'(NUM_FRAMES))
	`PFA_ASSERT_NOW(a_front_count_bound, clk, arst_n, table_active_q,
		page_count_q <= 4'(TABLE_DEPTH))

endmodule

[hw/rtl/pfa_back.sv]
// Back of the allocator: owns the frame bitmap and page table and emits results.
`include "page_frame_allocator_macros.svh"

module pfa_back
	import pfa_pkg::*;
#(
	parameter int NUM_FRAMES = DEF_NUM_FRAMES
) (
	input  logic    clk,
	input  logic    arst_n,
	input  cmd_t    head_cmd,
	input  logic    queue_empty,
	output logic    pop,
	output logic    out_valid,
	input  logic    out_ready,
	output result_t out_result
);

	localparam int FRAME_W = $clog2(NUM_FRAMES);
	localparam int FX_W    = (FRAME_W > 3) ? FRAME_W : 3;

	typedef enum logic [1:0] {
		BK_IDLE,
		BK_ALLOC,
		BK_RELEASE,
		BK_QUERY
	} back_state_t;

	back_state_t             state_q;
	cmd_t                    cmd_q;
	logic [TABLE_IDX_W-1:0]  idx_q;
	logic [NUM_FRAMES-1:0]   used_q;
	logic [FRAME_W-1:0]      table_q [TABLE_DEPTH];
	logic                    out_valid_q;
	result_t                 out_result_q;

	logic                    out_ok;
	logic                    last_step;
	logic [NUM_FRAMES-1:0]   free_vec;
	logic [NUM_FRAMES-1:0]   low_onehot;
	logic [FRAME_W-1:0]      low_frame;
	logic [FRAME_W-1:0]      table_rd;
	logic [FX_W-1:0]         alloc_fx;
	logic [FX_W-1:0]         table_fx;

	assign out_valid  = out_valid_q;
	assign out_result = out_result_q;

	// The output register can take a new result when empty or being drained.
	assign out_ok    = !out_valid_q || out_ready;
	assign pop       = (state_q == BK_IDLE) && !queue_empty && out_ok;
	assign last_step = ((4'(idx_q) + 4'd1) == cmd_q.count);
	assign table_rd  = table_q[idx_q];

	// Lowest free frame: isolate the lowest zero of the bitmap, then encode it.
	assign free_vec   = ~used_q;
	assign low_onehot = free_vec & (~free_vec + 1'b1);
	always_comb begin
		low_frame = '0;
		for (int i = 0; i < NUM_FRAMES; i++) begin
			if (low_onehot[i]) begin
				low_frame = low_frame | FRAME_W'(i);
			end
		end
	end

	// Frame numbers are reported by their low three bits.
	assign alloc_fx = FX_W'(low_frame);
	assign table_fx = FX_W'(table_rd);

	// Page table writes during allocation.
	always_ff @(posedge clk) begin
		if (state_q == BK_ALLOC && out_ok) begin
			table_q[idx_q] <= low_frame;
		end
	end

	// Sequencer, frame bitmap and output register.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q      <= BK_IDLE;
			cmd_q        <= '0;
			idx_q        <= '0;
			used_q       <= '0;
			out_valid_q  <= 1'b0;
			out_result_q <= '0;
		end else begin
			if (out_valid_q && out_ready) begin
				out_valid_q <= 1'b0;
			end
			case (state_q)
				BK_IDLE: begin
					if (pop) begin
						cmd_q <= head_cmd;
						idx_q <= '0;
						case (head_cmd.kind)
							CMD_ALLOC:   state_q <= BK_ALLOC;
							CMD_RELEASE: state_q <= BK_RELEASE;
							CMD_QUERY:   state_q <= BK_QUERY;
							default: begin
								out_valid_q  <= 1'b1;
								out_result_q <= '{last: 1'b1,
									free_frames: head_cmd.free_frames,
									entry_valid: 1'b0, frame_index: 3'd0,
									page_index: 3'd0, status: head_cmd.status};
							end
						endcase
					end
				end
				BK_ALLOC: begin
					if (out_ok) begin
						used_q[low_frame] <= 1'b1;
						out_valid_q       <= 1'b1;
						out_result_q      <= '{last: last_step,
							free_frames: cmd_q.free_frames, entry_valid: 1'b1,
							frame_index: alloc_fx[2:0], page_index: 3'(idx_q),
							status: ST_OK};
						idx_q <= idx_q + 1'b1;
						if (last_step) begin
							state_q <= BK_IDLE;
						end
					end
				end
				BK_QUERY: begin
					if (out_ok) begin
						out_valid_q  <= 1'b1;
						out_result_q <= '{last: last_step,
							free_frames: cmd_q.free_frames, entry_valid: 1'b1,
							frame_index: table_fx[2:0], page_index: 3'(idx_q),
							status: ST_OK};
						idx_q <= idx_q + 1'b1;
						if (last_step) begin
							state_q <= BK_IDLE;
						end
					end
				end
				BK_RELEASE: begin
					if (out_ok) begin
						used_q[table_rd] <= 1'b0;
						idx_q            <= idx_q + 1'b1;
						if (last_step) begin
							out_valid_q  <= 1'b1;
							out_result_q <= '{last: 1'b1,
								free_frames: cmd_q.free_frames, entry_valid: 1'b0,
								frame_index: 3'd0, page_index: 3'd0, status: ST_OK};
							state_q <= BK_IDLE;
						end
					end
				end
				default: begin
					state_q <= BK_IDLE;
				end
			endcase
		end
	end

	// Allocation always finds a free frame, and the page index stays inside the table.
	`PFA_ASSERT_NOW(a_back_frame_found, clk, arst_n, state_q == BK_ALLOC, low_onehot != '0)
	`PFA_ASSERT_NOW(a_back_idx_bound, clk, arst_n, state_q != BK_IDLE,
		4'(idx_q) < cmd_q.count)
	`PFA_ASSERT_NEXT(a_back_single_out, clk, arst_n, pop && head_cmd.kind == CMD_SINGLE,
		out_valid_q && out_result_q.last)

endmodule

[sim/pfa_checker.sv]
`timescale 1ns / 1ps
// Checker that mirrors the page frame allocator and compares every result transaction.
module pfa_checker
	import pfa_pkg::*;
#(
	parameter int NUM_FRAMES = DEF_NUM_FRAMES
) (
	input  logic        clk,
	input  logic        arst_n,
	input  logic        s_tvalid,
	input  logic        s_tready,
	input  logic [7:0]  s_tdata,  // op[1:0], page_request[5:2], zeros above
	input  logic        m_tvalid,
	input  logic        m_tready,
	input  logic [15:0] m_tdata,  // status[1:0], page_index[4:2], frame_index[7:5],
	                              // entry_valid[8], free_frames[12:9], zeros above
	input  logic        m_tlast,
	output int          mismatch_count,
	output int          results_owed
);

	// Mirrored allocator state: frame bitmap, page table and its ownership.
	logic [NUM_FRAMES-1:0] frames_in_use;
	int                    page_to_frame [TABLE_DEPTH];
	int                    pages_held;
	bit                    table_held;

	// Results still owed by the block, oldest first.
	result_t owed_results [$];
	int      mismatches = 0;

	// Queue one owed result; the free count reflects the mirror as it stands now.
	function automatic void owe_result(status_t status, int page, int frame, bit valid,
		bit final_one);
		result_t r;
		int      free_now;
		free_now = NUM_FRAMES - $countones(frames_in_use);
		r.status      = status;
		r.page_index  = page[2:0];
		r.frame_index = frame[2:0];
		r.entry_valid = valid;
		r.free_frames = free_now[3:0];
		r.last        = final_one;
		owed_results.push_back(r);
	endfunction

	// A held table is reported one mapping per page, or as a single empty entry.
	function automatic void owe_table_listing();
		if (pages_held == 0) begin
			owe_result(ST_OK, 0, 0, 1'b0, 1'b1);
		end else begin
			for (int i = 0; i < pages_held; i++)
				owe_result(ST_OK, i, page_to_frame[i], 1'b1, i == pages_held - 1);
		end
	endfunction

	// Apply one accepted request to the mirror and queue the results it causes.
	function automatic void map_request(logic [1:0] op, logic [3:0] pages);
		int free_now;
		int f;
		free_now = NUM_FRAMES - $countones(frames_in_use);
		f = 0;
		case (op)
			OP_ALLOC: begin
				if (table_held) begin
					owe_result(ST_HELD, 0, 0, 1'b0, 1'b1);
				end else if (int'(pages) > free_now || int'(pages) > TABLE_DEPTH) begin
					owe_result(ST_NO_FRAMES, 0, 0, 1'b0, 1'b1);
				end else begin
					// Page i goes to the i-th lowest free frame.
					pages_held = pages;
					table_held = 1'b1;
					for (int i = 0; i < int'(pages); i++) begin
						while (f < NUM_FRAMES && frames_in_use[f])
							f++;
						frames_in_use[f] = 1'b1;
						page_to_frame[i] = f;
					end
					owe_table_listing();
				end
			end
			OP_RELEASE: begin
				if (!table_held) begin
					owe_result(ST_NONE, 0, 0, 1'b0, 1'b1);
				end else begin
					for (int i = 0; i < pages_held; i++)
						frames_in_use[page_to_frame[i]] = 1'b0;
					table_held = 1'b0;
					owe_result(ST_OK, 0, 0, 1'b0, 1'b1);
				end
			end
			OP_QUERY: begin
				if (!table_held)
					owe_result(ST_NONE, 0, 0, 1'b0, 1'b1);
				else
					owe_table_listing();
			end
			default: begin
				// The unused opcode is dropped without a result.
			end
		endcase
	endfunction

	// Report one differing field and count it.
	function automatic int field_differs(string field, int want, int got);
		if (want == got)
			return 0;
		$display("%0t: %s mismatch, expected %0d, actual %0d", $time, field, want, got);
		return 1;
	endfunction

	// Retire result transactions against the oldest owed result, then take requests.
	always @(posedge clk or negedge arst_n) begin : watch_channels
		result_t got;
		result_t want;
		if (!arst_n) begin
			frames_in_use = '0;
			pages_held = 0;
			table_held = 1'b0;
			owed_results.delete();
			results_owed <= 0;
			mismatch_count <= mismatches;
		end else begin
			if (m_tvalid && m_tready) begin
				got = {m_tlast, m_tdata[12:0]};
				if (owed_results.size() == 0) begin
					$display("%0t: unexpected result, expected none, actual %h", $time, got);
					mismatches++;
				end else begin
					want = owed_results.pop_front();
					mismatches += field_differs("status", want.status, got.status);
					mismatches += field_differs("page_index", want.page_index, got.page_index);
					mismatches += field_differs("frame_index", want.frame_index,
						got.frame_index);
					mismatches += field_differs("entry_valid", want.entry_valid,
						got.entry_valid);
					mismatches += field_differs("free_frames", want.free_frames,
						got.free_frames);
					mismatches += field_differs("last", want.last, got.last);
				end
			end
			if (s_tvalid && s_tready)
				map_request(s_tdata[1:0], s_tdata[5:2]);
			results_owed <= owed_results.size();
			mismatch_count <= mismatches;
		end
	end

endmodule

[sim/tb_top.sv]
`timescale 1ns / 1ps
// Testbench top for the page frame allocator: clock, reset, request stimulus and verdict.
module tb_top
	import pfa_pkg::*;
();

	localparam logic [1:0] OP_UNUSED      = 2'd3;
	localparam int         PHASE_REQUESTS = 108;
	localparam int         SETTLE_CYCLES  = 20;

	logic        clk      = 1'b0;
	logic        arst_n   = 1'b0;
	logic        s_tvalid = 1'b0;
	logic [7:0]  s_tdata  = '0;
	logic        m_tready = 1'b0;
	logic        s_tready;
	logic        m_tvalid;
	logic [15:0] m_tdata;
	logic        m_tlast;

	int mismatch_count;
	int results_owed;
	int idle_pct = 0;
	int stall_pct = 0;
	int requests_sent = 0;

	page_frame_allocator dut (
		.clk      (clk),
		.arst_n   (arst_n),
		.s_tvalid (s_tvalid),
		.s_tready (s_tready),
		.s_tdata  (s_tdata),
		.m_tvalid (m_tvalid),
		.m_tready (m_tready),
		.m_tdata  (m_tdata),
		.m_tlast  (m_tlast)
	);

	pfa_checker check_results (
		.clk            (clk),
		.arst_n         (arst_n),
		.s_tvalid       (s_tvalid),
		.s_tready       (s_tready),
		.s_tdata        (s_tdata),
		.m_tvalid       (m_tvalid),
		.m_tready       (m_tready),
		.m_tdata        (m_tdata),
		.m_tlast        (m_tlast),
		.mismatch_count (mismatch_count),
		.results_owed   (results_owed)
	);

	// 2 ns clock.
	always begin
		#1 clk = 1'b1;
		#1 clk = 1'b0;
	end

	// Result side stalls at the rate of the current phase.
	always @(posedge clk) begin
		m_tready <= ($urandom_range(99) >= stall_pct);
	end

	// Offer one request, with random idle cycles first, and hold it until the transaction.
	task automatic send_request(input logic [1:0] op, input logic [3:0] pages);
		while ($urandom_range(99) < idle_pct) begin
			s_tvalid <= 1'b0;
			@(posedge clk);
		end
		s_tvalid <= 1'b1;
		s_tdata  <= {2'b00, pages, op};
		@(posedge clk);
		while (!s_tready)
			@(posedge clk);
		if (op != OP_UNUSED)
			requests_sent++;
	endtask

	// Hold off new requests until every owed result has come back.
	task automatic wait_for_results();
		s_tvalid <= 1'b0;
		@(posedge clk);
		while (results_owed != 0)
			@(posedge clk);
	endtask

	// A well-formed table lifetime: allocate, up to two reads, release.
	task automatic run_table_lifetime();
		logic [3:0] pages;
		int         reads;
		pages = ($urandom_range(9) == 0) ? 4'd0 : 4'($urandom_range(8, 1));
		reads = $urandom_range(2);
		send_request(OP_ALLOC, pages);
		repeat (reads)
			send_request(OP_QUERY, 4'($urandom_range(15)));
		send_request(OP_RELEASE, 4'($urandom_range(15)));
	endtask

	// One random phase with the given idle and stall rates.
	task automatic run_phase(input int idle, input int stall);
		idle_pct = idle;
		stall_pct <= stall;
		requests_sent = 0;
		while (requests_sent < PHASE_REQUESTS) begin
			if ($urandom_range(99) < 20)
				send_request(2'($urandom_range(3)), 4'($urandom_range(15)));
			else
				run_table_lifetime();
			if ($urandom_range(39) == 0)
				wait_for_results();
		end
		wait_for_results();
	endtask

	// Reset, directed cases, random phases and the verdict.
	initial begin
		repeat (5) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);

		// Nothing held yet, and the unused opcode.
		send_request(OP_QUERY, 4'd0);
		send_request(OP_RELEASE, 4'd15);
		send_request(OP_UNUSED, 4'd0);
		// Empty table: held with zero pages, then a second allocate is refused.
		send_request(OP_ALLOC, 4'd0);
		send_request(OP_QUERY, 4'd0);
		send_request(OP_ALLOC, 4'd1);
		send_request(OP_RELEASE, 4'd0);
		// Every frame mapped.
		send_request(OP_ALLOC, 4'd8);
		send_request(OP_QUERY, 4'd15);
		send_request(OP_ALLOC, 4'd2);
		send_request(OP_RELEASE, 4'd0);
		// Requests wider than the frame count.
		send_request(OP_ALLOC, 4'd9);
		send_request(OP_ALLOC, 4'd15);
		// Ordinary tables, then release and read with nothing held.
		send_request(OP_ALLOC, 4'd1);
		send_request(OP_QUERY, 4'd0);
		send_request(OP_RELEASE, 4'd0);
		send_request(OP_ALLOC, 4'd5);
		send_request(OP_QUERY, 4'd10);
		send_request(OP_RELEASE, 4'd5);
		send_request(OP_RELEASE, 4'd0);
		send_request(OP_QUERY, 4'd0);
		send_request(OP_UNUSED, 4'd15);
		wait_for_results();

		run_phase(0, 0);
		run_phase(55, 0);
		run_phase(0, 55);
		run_phase(28, 28);

		repeat (SETTLE_CYCLES) @(posedge clk);
		if (mismatch_count == 0 && results_owed == 0)
			$display("RESULT: OK");
		else
			$display("RESULT: ERROR");
		$finish;
	end

	// Watchdog for a hung handshake.
	initial begin
		#2_000_000;
		$display("RESULT: ERROR");
		$finish;
	end

endmodule
